FILE: sv/pls_pkg.sv
// Package for the path length segmenter.
// Holds default widths, the threshold reset value and the control/status structs.
// No dependencies.
`default_nettype none

package pls_pkg;

  localparam int unsigned COORD_WIDTH_DEF  = 24;
  localparam int unsigned LENGTH_WIDTH_DEF = 32;
  localparam int unsigned LIMIT_WIDTH      = 32;
  localparam int unsigned SEG_WIDTH        = 16;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 32'd25600;

  // Square unit operand select
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       diff;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       sum_en;
    logic       root_step;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/pls_point_if.sv
// Input channel of the path length segmenter: one path point per beat.
// Depends on pls_pkg for the default coordinate width.
`default_nettype none

interface pls_point_if #(
  parameter int unsigned COORD_WIDTH = pls_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic                          path_first;
  logic                          path_last;

  modport source (
    output valid, point_x, point_y, point_z, path_first, path_last,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, path_first, path_last,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/pls_result_if.sv
// Output channel of the path length segmenter: one tagged point per beat.
// Depends on pls_pkg for default widths.
`default_nettype none

interface pls_result_if #(
  parameter int unsigned COORD_WIDTH  = pls_pkg::COORD_WIDTH_DEF,
  parameter int unsigned LENGTH_WIDTH = pls_pkg::LENGTH_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [COORD_WIDTH-1:0]   out_x;
  logic signed [COORD_WIDTH-1:0]   out_y;
  logic signed [COORD_WIDTH-1:0]   out_z;
  logic [pls_pkg::SEG_WIDTH-1:0]   segment_number;
  logic                            closes_segment;
  logic                            ends_path;
  logic [LENGTH_WIDTH-1:0]         running_length;

  modport source (
    output valid, out_x, out_y, out_z, segment_number, closes_segment, ends_path,
           running_length,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, segment_number, closes_segment, ends_path,
           running_length,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/path_length_segmenter.sv
// Path length segmenter: one point at a time; a new point is accepted only after the
// previous result has been committed to the output register.
// A point marked path_first skips the distance computation.
// The square root loop produces one result bit per cycle.
// Asynchronous active-low reset: threshold to 25600, previous point, length and count to 0.
// Top level; depends on pls_pkg, pls_point_if, pls_result_if, pls_ctrl and pls_dp.
`default_nettype none

module path_length_segmenter #(
  parameter int unsigned COORD_WIDTH  = pls_pkg::COORD_WIDTH_DEF,
  parameter int unsigned LENGTH_WIDTH = pls_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  pls_point_if.sink                            point_i,
  pls_result_if.source                         result_o,
  input  wire logic                            length_limit_we_i,
  input  wire logic [pls_pkg::LIMIT_WIDTH-1:0] length_limit_i
);

  pls_pkg::cmd_t    cmd;
  pls_pkg::status_t status;
  logic             in_ready;

  assign point_i.ready = in_ready;

  pls_ctrl #(
    .ROOT_STEPS (COORD_WIDTH + 1)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (point_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pls_dp #(
    .COORD_WIDTH  (COORD_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .point_x_i         (point_i.point_x),
    .point_y_i         (point_i.point_y),
    .point_z_i         (point_i.point_z),
    .path_first_i      (point_i.path_first),
    .path_last_i       (point_i.path_last),
    .length_limit_we_i (length_limit_we_i),
    .length_limit_i    (length_limit_i),
    .result_o          (result_o)
  );

endmodule

`default_nettype wire

FILE: sv/pls_ctrl.sv
// Sequencer of the path length segmenter: capture, delta, squares, root, commit.
// Depends on pls_pkg (cmd_t, status_t, default coordinate width).
`default_nettype none

module pls_ctrl #(
  parameter int unsigned ROOT_STEPS = pls_pkg::COORD_WIDTH_DEF + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire pls_pkg::status_t status_i,
  output pls_pkg::cmd_t         cmd_o
);

  localparam int unsigned CNT_W = $clog2(ROOT_STEPS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIFF   = 3'd1;
  localparam logic [2:0] S_SQ     = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DIFF;
        end
      end
      S_DIFF: begin
        if (status_i.first) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.diff = 1'b1;
          cnt_d      = '0;
          state_d    = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_en  = (cnt_q != SQ_LAST);
        cmd_o.sq_sel = cnt_q[1:0];
        cmd_o.sum_en = (cnt_q != '0);
        if (cnt_q == SQ_LAST) begin
          cnt_d   = '0;
          state_d = S_ROOT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == ROOT_LAST) begin
          state_d = S_COMMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_commit_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> in_ready_o)
    else $error("input not reopened after commit");

  a_capture_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !in_ready_o)
    else $error("input still open while a point is in work");

endmodule

`default_nettype wire

FILE: sv/pls_dp.sv
// Datapath of the path length segmenter: point registers, shared squarer,
// bit-per-cycle integer square root, length accumulator and output register.
// Depends on pls_pkg and pls_result_if.
`default_nettype none

module pls_dp #(
  parameter int unsigned COORD_WIDTH  = pls_pkg::COORD_WIDTH_DEF,
  parameter int unsigned LENGTH_WIDTH = pls_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire pls_pkg::cmd_t                        cmd_i,
  output pls_pkg::status_t                          status_o,
  input  wire logic signed [COORD_WIDTH-1:0]        point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]        point_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]        point_z_i,
  input  wire logic                                 path_first_i,
  input  wire logic                                 path_last_i,
  input  wire logic                                 length_limit_we_i,
  input  wire logic [pls_pkg::LIMIT_WIDTH-1:0]      length_limit_i,
  pls_result_if.source                              result_o
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned LW     = LENGTH_WIDTH;
  localparam int unsigned SW     = pls_pkg::SEG_WIDTH;
  localparam int unsigned ROOT_W = CW + 1;
  localparam int unsigned PROD_W = 2 * CW;
  localparam int unsigned SUM_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned TRY_W  = ROOT_W + 4;
  localparam int unsigned ACC_W  = ((LW > ROOT_W) ? LW : ROOT_W) + 1;
  localparam int unsigned CMP_W  = (LW > pls_pkg::LIMIT_WIDTH) ? LW : pls_pkg::LIMIT_WIDTH;

  // Architectural state
  logic [pls_pkg::LIMIT_WIDTH-1:0] limit_q;
  logic signed [CW-1:0]            prev_x_q, prev_y_q, prev_z_q;
  logic [LW-1:0]                   seg_len_q;
  logic [SW-1:0]                   seg_cnt_q;
  logic                            out_valid_q;

  // Working registers
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic                 first_q, last_q;
  logic [CW-1:0]        dx_q, dy_q, dz_q;
  logic [PROD_W-1:0]    prod_q;
  logic [SUM_W-1:0]     sum_q;
  logic [ROOT_W-1:0]    root_q;
  logic [REM_W-1:0]     rem_q;

  // Output register
  logic signed [CW-1:0] res_x_q, res_y_q, res_z_q;
  logic [SW-1:0]        res_num_q;
  logic                 res_close_q, res_end_q;
  logic [LW-1:0]        res_len_q;

  // Absolute coordinate deltas
  logic [CW:0] diff_x, diff_y, diff_z;
  logic [CW:0] abs_x, abs_y, abs_z;

  assign diff_x = {x_q[CW-1], x_q} - {prev_x_q[CW-1], prev_x_q};
  assign diff_y = {y_q[CW-1], y_q} - {prev_y_q[CW-1], prev_y_q};
  assign diff_z = {z_q[CW-1], z_q} - {prev_z_q[CW-1], prev_z_q};
  assign abs_x  = diff_x[CW] ? (~diff_x + (CW+1)'(1)) : diff_x;
  assign abs_y  = diff_y[CW] ? (~diff_y + (CW+1)'(1)) : diff_y;
  assign abs_z  = diff_z[CW] ? (~diff_z + (CW+1)'(1)) : diff_z;

  // Shared squarer operand
  logic [CW-1:0] sq_op;

  always_comb begin
    unique case (cmd_i.sq_sel)
      pls_pkg::SEL_X: sq_op = dx_q;
      pls_pkg::SEL_Y: sq_op = dy_q;
      pls_pkg::SEL_Z: sq_op = dz_q;
      default:        sq_op = '0;
    endcase
  end

  // Restoring square root, one result bit per step
  logic [TRY_W-1:0] rem_sh, trial, rem_sub;
  logic             take;

  assign rem_sh  = {rem_q, sum_q[SUM_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign take    = (rem_sh >= trial);

  // Length update
  logic [ACC_W-1:0] acc;
  logic [LW-1:0]    len_sat;
  logic             closes;

  assign acc     = ACC_W'(seg_len_q) + ACC_W'(root_q);
  assign len_sat = (|acc[ACC_W-1:LW]) ? '1 : acc[LW-1:0];
  assign closes  = (CMP_W'(len_sat) > CMP_W'(limit_q));

  assign status_o.first    = first_q;
  assign status_o.out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q     <= point_x_i;
      y_q     <= point_y_i;
      z_q     <= point_z_i;
      first_q <= path_first_i;
      last_q  <= path_last_i;
    end
    if (cmd_i.diff) begin
      dx_q <= abs_x[CW-1:0];
      dy_q <= abs_y[CW-1:0];
      dz_q <= abs_z[CW-1:0];
    end
    if (cmd_i.sq_en) begin
      prod_q <= sq_op * sq_op;
    end
    if (cmd_i.diff) begin
      sum_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
    end else if (cmd_i.sum_en) begin
      sum_q <= sum_q + SUM_W'(prod_q);
    end else if (cmd_i.root_step) begin
      sum_q  <= {sum_q[SUM_W-3:0], 2'b00};
      root_q <= {root_q[ROOT_W-2:0], take};
      rem_q  <= take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
    end
    if (cmd_i.commit) begin
      res_x_q   <= x_q;
      res_y_q   <= y_q;
      res_z_q   <= z_q;
      res_end_q <= last_q;
      if (first_q) begin
        res_num_q   <= '0;
        res_close_q <= 1'b0;
        res_len_q   <= '0;
      end else begin
        res_num_q   <= seg_cnt_q;
        res_close_q <= closes;
        res_len_q   <= len_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= pls_pkg::LIMIT_RESET;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      seg_len_q   <= '0;
      seg_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (length_limit_we_i) begin
        limit_q <= length_limit_i;
      end
      if (cmd_i.commit) begin
        prev_x_q    <= x_q;
        prev_y_q    <= y_q;
        prev_z_q    <= z_q;
        out_valid_q <= 1'b1;
        if (first_q) begin
          seg_len_q <= '0;
          seg_cnt_q <= '0;
        end else if (closes) begin
          seg_len_q <= '0;
          if (seg_cnt_q != '1) begin
            seg_cnt_q <= seg_cnt_q + SW'(1);
          end
        end else begin
          seg_len_q <= len_sat;
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.out_x          = res_x_q;
  assign result_o.out_y          = res_y_q;
  assign result_o.out_z          = res_z_q;
  assign result_o.segment_number = res_num_q;
  assign result_o.closes_segment = res_close_q;
  assign result_o.ends_path      = res_end_q;
  assign result_o.running_length = res_len_q;

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> status_o.out_free)
    else $error("result committed over an untaken beat");

  a_close_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.closes_segment) |-> (result_o.running_length != '0))
    else $error("segment closed with zero length");

  a_first_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && first_q) |=>
      (seg_len_q == '0 && seg_cnt_q == '0 && !result_o.closes_segment))
    else $error("path start did not restart the segment");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for path_length_segmenter: drives path points, predicts every tagged
// result beat in a cycle-free model and checks the output beat by beat.
// Depends on pls_pkg, pls_point_if, pls_result_if and the segmenter RTL.

module tb_top;

  localparam int unsigned CW = pls_pkg::COORD_WIDTH_DEF;
  localparam int unsigned LW = pls_pkg::LENGTH_WIDTH_DEF;
  localparam int unsigned SW = pls_pkg::SEG_WIDTH;
  localparam longint unsigned LEN_MAX = (64'd1 << LW) - 64'd1;
  localparam int unsigned TIMEOUT_CYCLES = 500000;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 first;
    logic                 last;
  } path_point_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [SW-1:0]        seg;
    logic                 closes;
    logic                 ends;
    logic [LW-1:0]        len;
  } seg_beat_t;

  logic clk_i;
  logic rst_ni;
  logic limit_we;
  logic [pls_pkg::LIMIT_WIDTH-1:0] limit_data;

  pls_point_if  point_bus ();
  pls_result_if result_bus ();

  path_length_segmenter i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .point_i           (point_bus),
    .result_o          (result_bus),
    .length_limit_we_i (limit_we),
    .length_limit_i    (limit_data)
  );

  path_point_t pending_points[$];
  seg_beat_t   expected_beats[$];
  path_point_t offered;

  // segmenter state as seen from outside
  logic signed [CW-1:0] last_x, last_y, last_z;
  longint unsigned      open_len;
  logic [SW-1:0]        open_seg;
  logic [pls_pkg::LIMIT_WIDTH-1:0] limit_q;

  int          fail_count = 0;
  int          points_taken = 0;
  int          beats_seen = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  int unsigned cycle_count = 0;

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned r, c;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic seg_beat_t segment_step(path_point_t p);
    seg_beat_t r;
    longint dx, dy, dz;
    longint unsigned d;
    r.x = p.x;
    r.y = p.y;
    r.z = p.z;
    r.ends = p.last;
    r.closes = 1'b0;
    if (p.first) begin
      open_len = 0;
      open_seg = '0;
      r.seg = '0;
      r.len = '0;
    end else begin
      dx = longint'(p.x) - longint'(last_x);
      dy = longint'(p.y) - longint'(last_y);
      dz = longint'(p.z) - longint'(last_z);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      d = floor_sqrt(longint'(dx * dx + dy * dy + dz * dz));
      if (d > LEN_MAX - open_len) open_len = LEN_MAX;
      else open_len = open_len + d;
      r.seg = open_seg;
      r.len = open_len[LW-1:0];
      if (open_len > limit_q) begin
        r.closes = 1'b1;
        open_len = 0;
        if (open_seg != '1) open_seg = open_seg + 1'b1;
      end
    end
    last_x = p.x;
    last_y = p.y;
    last_z = p.z;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic push_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z, logic first, logic last);
    path_point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.first = first;
    p.last = last;
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || point_bus.valid || expected_beats.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_limit(logic [pls_pkg::LIMIT_WIDTH-1:0] v);
    @(posedge clk_i);
    limit_we <= 1'b1;
    limit_data <= v;
    @(posedge clk_i);
    limit_we <= 1'b0;
    limit_q = v;
  endtask

  // mostly well-formed paths with random start, step scale and length; some noise
  task automatic random_paths(int n);
    int made, k;
    int unsigned s;
    logic signed [CW-1:0] x, y, z;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 2) begin
        push_point(CW'($urandom()), CW'($urandom()), CW'($urandom()),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        k = $urandom_range(1, 24);
        s = 1 << $urandom_range(1, 22);
        x = CW'($urandom());
        y = CW'($urandom());
        z = CW'($urandom());
        for (int i = 0; i < k; i++) begin
          if (i > 0) begin
            x = CW'(x + ($urandom_range(0, 2 * s) - s));
            y = CW'(y + ($urandom_range(0, 2 * s) - s));
            z = CW'(z + ($urandom_range(0, 2 * s) - s));
          end
          push_point(x, y, z, i == 0 && $urandom_range(0, 9) != 0,
                     i == k - 1 && $urandom_range(0, 9) != 0);
        end
        made += k;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // point driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_bus.valid <= 1'b0;
    end else begin
      if (point_bus.valid && point_bus.ready) begin
        expected_beats.insert(expected_beats.size(), segment_step(offered));
        points_taken <= points_taken + 1;
      end
      if (!(point_bus.valid && !point_bus.ready)) begin
        if (pending_points.size() != 0 &&
            !($urandom_range(0, 99) < 17 && !(points_taken >= 300 && points_taken < 420))) begin
          offered = pending_points.pop_front();
          point_bus.valid <= 1'b1;
          point_bus.point_x <= offered.x;
          point_bus.point_y <= offered.y;
          point_bus.point_z <= offered.z;
          point_bus.path_first <= offered.first;
          point_bus.path_last <= offered.last;
        end else begin
          point_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generation
  always @(posedge clk_i or negedge rst_ni) begin
    seg_beat_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        beats_seen <= beats_seen + 1;
        if (expected_beats.size() == 0) begin
          $error("result beat with no point pending");
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("out_x", want.x, result_bus.out_x);
          check_field("out_y", want.y, result_bus.out_y);
          check_field("out_z", want.z, result_bus.out_z);
          check_field("segment_number", want.seg, result_bus.segment_number);
          check_field("closes_segment", want.closes, result_bus.closes_segment);
          check_field("ends_path", want.ends, result_bus.ends_path);
          check_field("running_length", want.len, result_bus.running_length);
        end
      end
      if (!long_hold_done && beats_seen == 200) begin
        long_hold_done <= 1'b1;
        hold_left <= 500;
        result_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= (beats_seen >= 450 && beats_seen < 560) ||
                            $urandom_range(0, 99) >= 17;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    limit_we = 1'b0;
    limit_data = pls_pkg::LIMIT_RESET;
    point_bus.valid = 1'b0;
    point_bus.point_x = '0;
    point_bus.point_y = '0;
    point_bus.point_z = '0;
    point_bus.path_first = 1'b0;
    point_bus.path_last = 1'b0;
    result_bus.ready = 1'b0;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    open_len = 0;
    open_seg = '0;
    limit_q = pls_pkg::LIMIT_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold: measured from origin, exact-threshold tie, extremes, marks
    push_point(256, 0, 0, 1'b0, 1'b0);
    push_point(0, 0, 0, 1'b1, 1'b0);
    push_point(25600, 0, 0, 1'b0, 1'b0);
    push_point(25601, 0, 0, 1'b0, 1'b0);
    push_point(25601, 0, 0, 1'b0, 1'b0);
    push_point(-8388608, -8388608, -8388608, 1'b0, 1'b1);
    push_point(8388607, 8388607, 8388607, 1'b0, 1'b0);
    push_point(8388607, -8388608, 0, 1'b1, 1'b1);
    push_point(-8388608, 8388607, -8388608, 1'b1, 1'b0);
    push_point(8388607, -8388608, 8388607, 1'b0, 1'b0);
    push_point(100, 100, 100, 1'b1, 1'b0);
    push_point(150, 100, 100, 1'b0, 1'b0);
    push_point(150, 150, -150, 1'b0, 1'b0);
    push_point(24'h555555, 24'h2AAAAA, -1, 1'b0, 1'b1);
    drain();

    // zero threshold: any nonzero step closes, a repeated point does not
    write_limit('0);
    push_point(0, 0, 0, 1'b1, 1'b0);
    push_point(0, 0, 0, 1'b0, 1'b0);
    push_point(1, 0, 0, 1'b0, 1'b0);
    push_point(1, 0, 0, 1'b0, 1'b0);
    push_point(1, 3, 4, 1'b0, 1'b0);
    push_point(-8388608, 8388607, 0, 1'b0, 1'b0);
    push_point(-8388608, 8388607, 0, 1'b0, 1'b1);
    drain();

    // all-ones threshold: long zigzag saturates the length, nothing closes
    write_limit('1);
    push_point(-8388608, -8388608, -8388608, 1'b1, 1'b0);
    for (int i = 0; i < 154; i++) begin
      if (i % 2 == 0) push_point(8388607, 8388607, 8388607, 1'b0, i == 153);
      else push_point(-8388608, -8388608, -8388608, 1'b0, i == 153);
    end
    drain();

    write_limit(1);
    random_paths(95);
    drain();
    write_limit($urandom_range(100, 3000));
    random_paths(95);
    drain();
    write_limit(pls_pkg::LIMIT_RESET);
    random_paths(95);
    drain();
    write_limit($urandom());
    random_paths(95);
    drain();
    write_limit($urandom_range(0, 100000));
    random_paths(95);
    drain();

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_beats.size() != 0)
        $error("%0d result beats never arrived", expected_beats.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pls_pkg.sv
sv/pls_point_if.sv
sv/pls_result_if.sv
sv/pls_ctrl.sv
sv/pls_dp.sv
sv/path_length_segmenter.sv
bench/tb_top.sv
